FILE: hdl/ntw_pkg.sv
// Shared types and constants for the number-to-words token block.
// Used by ntw_bcd_conv, ntw_tok_seq and number_to_english_word_tokens_core.
package ntw_pkg;

    // Input value and decimal digit geometry.
    localparam int VALUE_W = 31;
    localparam int NUM_DIG = 10;
    localparam int DIG_W   = 4;
    localparam int CNT_W   = $clog2(VALUE_W + 1);
    localparam int TOK_W   = 5;

    // Word token codes.
    localparam logic [TOK_W-1:0] TOK_ZERO      = 5'd0;
    localparam logic [TOK_W-1:0] TOK_TEN       = 5'd10;
    localparam logic [TOK_W-1:0] TOK_TENS_BASE = 5'd18;
    localparam logic [TOK_W-1:0] TOK_HUNDRED   = 5'd28;
    localparam logic [TOK_W-1:0] TOK_THOUSAND  = 5'd29;
    localparam logic [TOK_W-1:0] TOK_MILLION   = 5'd30;
    localparam logic [TOK_W-1:0] TOK_BILLION   = 5'd31;

    // Index of the last digit group (the plain remainder, no scale word).
    localparam logic [1:0] GRP_LAST = 2'd3;

    // Packed decimal digits, digit 0 is the least significant.
    typedef logic [NUM_DIG-1:0][DIG_W-1:0] t_bcd;

    // One output beat from the token sequencer.
    typedef struct packed {
        logic             vld;
        logic [TOK_W-1:0] word;
        logic             last;
    } t_tok_beat;

endpackage

FILE: hdl/ntw_bcd_conv.sv
// Bit-serial binary to decimal converter (shift and add-3), one bit per cycle.
// Depends on ntw_pkg for widths and the digit vector type.
module ntw_bcd_conv import ntw_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_go,
    input  logic [VALUE_W-1:0] i_value,
    output logic               o_done,
    output t_bcd               o_bcd
);

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_SHIFT = 2'b10
    } t_state;

    t_state                     r_state, n_state;
    logic [VALUE_W-1:0]         r_bin, n_bin;
    t_bcd                       r_bcd, n_bcd;
    logic [CNT_W-1:0]           r_cnt, n_cnt;
    logic                       r_done, n_done;
    t_bcd                       w_adj;
    logic [NUM_DIG*DIG_W-1:0]   w_adj_bits;

    // Add three to every digit of five or more before the shift.
    always_comb begin
        for (int d = 0; d < NUM_DIG; d++) begin
            w_adj[d] = (r_bcd[d] >= DIG_W'(5)) ? r_bcd[d] + DIG_W'(3) : r_bcd[d];
        end
    end

    // Flat view of the adjusted digits for the one-bit shift.
    assign w_adj_bits = w_adj;

    // Sequencer: load, then shift one input bit into the digits per cycle.
    always_comb begin
        n_state = r_state;
        n_bin   = r_bin;
        n_bcd   = r_bcd;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_go) begin
                    n_bin   = i_value;
                    n_bcd   = '0;
                    n_cnt   = '0;
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                n_bcd = t_bcd'({w_adj_bits[NUM_DIG*DIG_W-2:0], r_bin[VALUE_W-1]});
                n_bin = {r_bin[VALUE_W-2:0], 1'b0};
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(VALUE_W - 1)) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_cnt   <= n_cnt;
        end
        r_bin <= n_bin;
        r_bcd <= n_bcd;
    end

    assign o_done = r_done;
    assign o_bcd  = r_bcd;

endmodule

FILE: hdl/ntw_tok_seq.sv
// Token sequencer: walks the four digit groups and emits one word per beat.
// Depends on ntw_pkg for token codes, the digit vector and the beat struct.
module ntw_tok_seq import ntw_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_go,
    input  t_bcd      i_bcd,
    output t_tok_beat o_beat
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_HDIG  = 7'b0000010,
        S_HWORD = 7'b0000100,
        S_TENS  = 7'b0001000,
        S_UNITS = 7'b0010000,
        S_SCALE = 7'b0100000,
        S_FLUSH = 7'b1000000
    } t_state;

    t_state           r_state, n_state;
    t_bcd             r_dig, n_dig;
    logic [1:0]       r_grp, n_grp;
    logic             r_pend_vld, n_pend_vld;
    logic [TOK_W-1:0] r_pend, n_pend;
    t_tok_beat        r_beat, n_beat;

    logic [DIG_W-1:0] w_h, w_t, w_u;
    logic             w_nz;
    logic             w_emit;
    logic [TOK_W-1:0] w_tok;

    // Pick the hundreds, tens and units digits of the current group.
    always_comb begin
        unique case (r_grp)
            2'd0: begin
                w_h = '0;
                w_t = '0;
                w_u = r_dig[9];
            end
            2'd1: begin
                w_h = r_dig[8];
                w_t = r_dig[7];
                w_u = r_dig[6];
            end
            2'd2: begin
                w_h = r_dig[5];
                w_t = r_dig[4];
                w_u = r_dig[3];
            end
            default: begin
                w_h = r_dig[2];
                w_t = r_dig[1];
                w_u = r_dig[0];
            end
        endcase
        w_nz = (w_h != '0) || (w_t != '0) || (w_u != '0);
    end

    // Step through the phases of a group; each phase yields at most one token.
    always_comb begin
        n_state = r_state;
        n_dig   = r_dig;
        n_grp   = r_grp;
        w_emit  = 1'b0;
        w_tok   = TOK_ZERO;
        unique case (r_state)
            S_IDLE: begin
                if (i_go) begin
                    n_dig   = i_bcd;
                    n_grp   = '0;
                    n_state = (i_bcd == '0) ? S_FLUSH : S_HDIG;
                end
            end
            S_HDIG: begin
                w_emit  = (w_h != '0);
                w_tok   = TOK_W'(w_h);
                n_state = S_HWORD;
            end
            S_HWORD: begin
                w_emit  = (w_h != '0);
                w_tok   = TOK_HUNDRED;
                n_state = S_TENS;
            end
            S_TENS: begin
                // Twenty and above take a tens word; ten to nineteen are one word.
                priority if (w_t >= DIG_W'(2)) begin
                    w_emit = 1'b1;
                    w_tok  = TOK_TENS_BASE + TOK_W'(w_t);
                end else if (w_t == DIG_W'(1)) begin
                    w_emit = 1'b1;
                    w_tok  = TOK_TEN + TOK_W'(w_u);
                end else begin
                    w_emit = (w_u != '0);
                    w_tok  = TOK_W'(w_u);
                end
                n_state = S_UNITS;
            end
            S_UNITS: begin
                w_emit  = (w_t >= DIG_W'(2)) && (w_u != '0);
                w_tok   = TOK_W'(w_u);
                n_state = S_SCALE;
            end
            S_SCALE: begin
                w_emit = w_nz && (r_grp != GRP_LAST);
                w_tok  = TOK_BILLION - TOK_W'(r_grp);
                if (r_grp == GRP_LAST) begin
                    n_state = S_FLUSH;
                end else begin
                    n_grp   = r_grp + 2'd1;
                    n_state = S_HDIG;
                end
            end
            S_FLUSH: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold one token back so the final one can carry the last flag.
    always_comb begin
        n_pend_vld = r_pend_vld;
        n_pend     = r_pend;
        n_beat     = '0;
        priority if (r_state == S_IDLE && i_go) begin
            n_pend_vld = (i_bcd == '0);
            n_pend     = TOK_ZERO;
        end else if (r_state == S_FLUSH) begin
            n_beat     = '{vld: r_pend_vld, word: r_pend, last: 1'b1};
            n_pend_vld = 1'b0;
        end else if (w_emit) begin
            n_beat     = '{vld: r_pend_vld, word: r_pend, last: 1'b0};
            n_pend_vld = 1'b1;
            n_pend     = w_tok;
        end else begin
            n_pend_vld = r_pend_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_grp      <= '0;
            r_pend_vld <= 1'b0;
            r_beat     <= '0;
        end else begin
            r_state    <= n_state;
            r_grp      <= n_grp;
            r_pend_vld <= n_pend_vld;
            r_beat     <= n_beat;
        end
        r_dig  <= n_dig;
        r_pend <= n_pend;
    end

    assign o_beat = r_beat;

endmodule

FILE: hdl/number_to_english_word_tokens_core.sv
// Top level of the number-to-words token block: command handshake and busy.
// Depends on ntw_pkg, ntw_bcd_conv and ntw_tok_seq.
//
//  channel  | ports                 | handshake
//  ---------+-----------------------+-------------------------------------
//  input    | i_value               | taken when start is high, busy low
//  result   | o_word, o_last        | one cycle each, marked by o_strobe
//
// After the accepting edge an item passes the shift-and-add-3 converter, which
// shifts in all 31 bits of the value, the register that hands the digits over,
// the token sequencer (five phases for each of four digit groups), the flush
// state and the output register. busy drops after the final token has been on
// the ports, so a new item is taken only once the last is through. A value of
// zero skips the groups and goes from the hand-over straight to the flush state.
// Tokens come one per beat at most; o_last marks the final one.
// busy stays high from the accepted beat until after the final result beat.
// Reset is synchronous and active low; results cannot be held off.
module number_to_english_word_tokens_core import ntw_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic [VALUE_W-1:0] i_value,
    output logic               busy,
    output logic               o_strobe,
    output logic [TOK_W-1:0]   o_word,
    output logic               o_last
);

    logic      r_busy, n_busy;
    logic      w_accept;
    logic      w_conv_done;
    t_bcd      w_bcd;
    t_tok_beat w_beat;

    assign w_accept = start && !r_busy;

    // Busy from the accepted beat until the final token has gone out.
    always_comb begin
        n_busy = r_busy;
        priority if (w_accept) begin
            n_busy = 1'b1;
        end else if (w_beat.vld && w_beat.last) begin
            n_busy = 1'b0;
        end else begin
            n_busy = r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
    end

    ntw_bcd_conv u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (w_accept),
        .i_value (i_value),
        .o_done  (w_conv_done),
        .o_bcd   (w_bcd)
    );

    ntw_tok_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (w_conv_done),
        .i_bcd   (w_bcd),
        .o_beat  (w_beat)
    );

    assign busy     = r_busy;
    assign o_strobe = w_beat.vld;
    assign o_word   = w_beat.word;
    assign o_last   = w_beat.last;

endmodule
